FILE: src/png_scanline_unfilter_core_assert.svh
// Assertion macros shared by the unfilter RTL.
// Needs a clock named aclk and an active-low reset named aresetn in scope.
`ifndef PNG_SCANLINE_UNFILTER_CORE_ASSERT_SVH
`define PNG_SCANLINE_UNFILTER_CORE_ASSERT_SVH

// condition holds at every edge out of reset
`define UNF_ASSERT(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define UNF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/png_unf_pkg.sv
// Shared types, constants and helper functions for the PNG unfilter core.
// No dependencies.
package png_unf_pkg;

    localparam int MAX_ROW_BYTES = 8192;
    localparam int IDX_W         = $clog2(MAX_ROW_BYTES);
    localparam int CNT_W         = IDX_W + 1;
    localparam int FIFO_DEPTH    = 4;
    localparam int FIFO_PTR_W    = $clog2(FIFO_DEPTH);
    localparam int CFG_IDX_W     = 1;
    localparam int CFG_DATA_W    = 14;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BPP       = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_BYTES = 1'd1;

    // filter type codes
    localparam logic [7:0] FILT_NONE  = 8'd0;
    localparam logic [7:0] FILT_SUB   = 8'd1;
    localparam logic [7:0] FILT_UP    = 8'd2;
    localparam logic [7:0] FILT_AVG   = 8'd3;
    localparam logic [7:0] FILT_PAETH = 8'd4;

    // one classified sample, front to back
    typedef struct packed {
        logic [IDX_W-1:0] idx;        // byte index within the row
        logic [1:0]       lane;       // idx mod bytes per pixel
        logic             has_left;   // idx >= bytes per pixel
        logic             first_row;  // no row above yet
        logic [7:0]       filter;
        logic [7:0]       sample;
        logic             last;       // last byte of the row
    } item_t;

    // row index modulo the effective pixel size (1..4)
    function automatic logic [1:0] lane_of(input logic [IDX_W-1:0] idx,
                                           input logic [2:0] bpp);
        localparam int NDIG = (IDX_W + 1) / 2;
        logic [2*NDIG-1:0] pad;
        logic [4:0]        sum;
        logic [2:0]        s2;
        logic [1:0]        res;
        pad = (2*NDIG)'(idx);
        sum = '0;
        // 4 = 1 mod 3: base-4 digit sum keeps the residue
        for (int k = 0; k < NDIG; k++) begin
            sum = sum + 5'(pad[2*k +: 2]);
        end
        s2 = 3'(sum[1:0]) + 3'(sum[3:2]) + 3'(sum[4]);
        if (s2 >= 3'd6) begin
            s2 = s2 - 3'd6;
        end else if (s2 >= 3'd3) begin
            s2 = s2 - 3'd3;
        end
        case (bpp)
            3'd1:    res = 2'd0;
            3'd2:    res = {1'b0, idx[0]};
            3'd3:    res = s2[1:0];
            default: res = idx[1:0];
        endcase
        return res;
    endfunction

    // Paeth predictor
    function automatic logic [7:0] paeth(input logic [7:0] a, input logic [7:0] b,
                                         input logic [7:0] c);
        logic signed [9:0] da;
        logic signed [9:0] db;
        logic signed [9:0] pa;
        logic signed [9:0] pb;
        logic signed [9:0] pc;
        logic [7:0]        res;
        db = $signed({2'b0, b}) - $signed({2'b0, c});
        da = $signed({2'b0, a}) - $signed({2'b0, c});
        pa = (db < 0) ? -db : db;
        pb = (da < 0) ? -da : da;
        pc = ((da + db) < 0) ? -(da + db) : (da + db);
        if (pa <= pb && pa <= pc) begin
            res = a;
        end else if (pb <= pc) begin
            res = b;
        end else begin
            res = c;
        end
        return res;
    endfunction

endpackage

FILE: src/png_unf_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module png_unf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // read port, old data on a same-address write
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
endmodule

FILE: src/png_unf_front.sv
// Front end: config registers, row tracking, filter byte capture, sample classification.
// Depends on png_unf_pkg and the assertion macro header.
`include "png_scanline_unfilter_core_assert.svh"
module png_unf_front
    import png_unf_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,
    input  logic [0:0]            s_tuser,
    output logic                  push,
    output item_t                 push_item,
    input  logic                  fifo_full
);
    logic [2:0]       bpp_reg, bpp_next;
    logic [13:0]      row_bytes_reg, row_bytes_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             expect_filter_reg, expect_filter_next;
    logic             first_row_reg, first_row_next;
    logic [7:0]       filter_reg, filter_next;

    logic             accept;
    logic             is_filter;
    logic [2:0]       bpp_eff;
    logic [CNT_W-1:0] rb_eff;
    logic             last;

    assign cfg_ready = 1'b1;
    assign s_tready  = !fifo_full;
    assign accept    = s_tvalid && s_tready;
    assign is_filter = s_tuser[0] || expect_filter_reg;
    assign push      = accept && !is_filter;

    // clamp config to legal range
    always_comb begin
        if (bpp_reg == 3'd0) begin
            bpp_eff = 3'd1;
        end else if (bpp_reg > 3'd4) begin
            bpp_eff = 3'd4;
        end else begin
            bpp_eff = bpp_reg;
        end
        if (row_bytes_reg == 14'd0) begin
            rb_eff = CNT_W'(1);
        end else if (32'(row_bytes_reg) > MAX_ROW_BYTES) begin
            rb_eff = CNT_W'(MAX_ROW_BYTES);
        end else begin
            rb_eff = CNT_W'(row_bytes_reg);
        end
    end

    assign last = (CNT_W'(idx_reg) + CNT_W'(1)) >= rb_eff;

    // classified sample
    always_comb begin
        push_item.idx       = idx_reg;
        push_item.lane      = lane_of(idx_reg, bpp_eff);
        push_item.has_left  = CNT_W'(idx_reg) >= CNT_W'(bpp_eff);
        push_item.first_row = first_row_reg;
        push_item.filter    = filter_reg;
        push_item.sample    = s_tdata;
        push_item.last      = last;
    end

    // config writes
    always_comb begin
        bpp_next       = bpp_reg;
        row_bytes_next = row_bytes_reg;
        if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_BPP:       bpp_next = cfg_wdata[2:0];
                REG_ROW_BYTES: row_bytes_next = cfg_wdata[13:0];
                default:       bpp_next = bpp_reg;
            endcase
        end
    end

    // row position tracking
    always_comb begin
        idx_next           = idx_reg;
        expect_filter_next = expect_filter_reg;
        first_row_next     = first_row_reg;
        filter_next        = filter_reg;
        if (accept) begin
            if (is_filter) begin
                filter_next        = s_tdata;
                idx_next           = '0;
                expect_filter_next = 1'b0;
                if (s_tuser[0]) begin
                    first_row_next = 1'b1;
                end
            end else if (last) begin
                idx_next           = '0;
                expect_filter_next = 1'b1;
                first_row_next     = 1'b0;
            end else begin
                idx_next = idx_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bpp_reg           <= 3'd3;
            row_bytes_reg     <= 14'd180;
            idx_reg           <= '0;
            expect_filter_reg <= 1'b1;
            first_row_reg     <= 1'b1;
            filter_reg        <= FILT_NONE;
        end else begin
            bpp_reg           <= bpp_next;
            row_bytes_reg     <= row_bytes_next;
            idx_reg           <= idx_next;
            expect_filter_reg <= expect_filter_next;
            first_row_reg     <= first_row_next;
            filter_reg        <= filter_next;
        end
    end

    `UNF_ASSERT_NEXT(a_row_end_wants_filter, push && last, expect_filter_reg, "row end did not rearm filter byte")
endmodule

FILE: src/png_unf_fifo.sv
// Short register queue decoupling the front end from the reconstruction back end.
// Depends on png_unf_pkg and the assertion macro header.
`include "png_scanline_unfilter_core_assert.svh"
module png_unf_fifo
    import png_unf_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  push,
    input  item_t push_item,
    output logic  full,
    input  logic  pop,
    output logic  head_valid,
    output item_t head_item
);
    item_t                 mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_PTR_W:0]   count_reg, count_next;

    assign full       = count_reg == (FIFO_PTR_W+1)'(FIFO_DEPTH);
    assign head_valid = count_reg != '0;
    assign head_item  = mem_reg[rd_ptr_reg];

    // pointers and fill level
    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + FIFO_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + FIFO_PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + (FIFO_PTR_W+1)'(1);
        end else if (pop && !push) begin
            count_next = count_reg - (FIFO_PTR_W+1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    `UNF_ASSERT(a_fifo_bound, count_reg <= (FIFO_PTR_W+1)'(FIFO_DEPTH), "queue fill level out of range")
endmodule

FILE: src/png_unf_back.sv
// Back end: prior-row read, filter reconstruction, lane history and output register.
// Depends on png_unf_pkg, png_unf_ram and the assertion macro header.
`include "png_scanline_unfilter_core_assert.svh"
module png_unf_back
    import png_unf_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       head_valid,
    input  item_t      head_item,
    output logic       pop,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,
    output logic       m_tlast
);
    item_t      s1_reg, s1_next;
    logic       s1_valid_reg, s1_valid_next;
    logic       fwd_hit_reg, fwd_hit_next;
    logic [7:0] fwd_data_reg, fwd_data_next;
    logic [7:0] left_reg [4];
    logic [7:0] ul_reg [4];
    logic       m_tvalid_reg, m_tvalid_next;
    logic [7:0] m_tdata_reg, m_tdata_next;
    logic       m_tlast_reg, m_tlast_next;

    logic       s1_adv;
    logic [7:0] ram_rdata;
    logic [7:0] a, b, c, pred, res;
    logic [8:0] ab_sum;

    assign s1_adv = s1_valid_reg && (!m_tvalid_reg || m_tready);
    assign pop    = head_valid && (!s1_valid_reg || s1_adv);

    // previous row store
    png_unf_ram #(
        .WIDTH (8),
        .DEPTH (MAX_ROW_BYTES)
    ) u_prior_row (
        .aclk    (aclk),
        .wr_en   (s1_adv),
        .wr_addr (s1_reg.idx),
        .wr_data (res),
        .rd_en   (pop),
        .rd_addr (head_item.idx),
        .rd_data (ram_rdata)
    );

    // neighbours, with bypass of a write landing on the same edge as the read
    always_comb begin
        b = s1_reg.first_row ? 8'd0 : (fwd_hit_reg ? fwd_data_reg : ram_rdata);
        a = s1_reg.has_left ? left_reg[s1_reg.lane] : 8'd0;
        c = (s1_reg.has_left && !s1_reg.first_row) ? ul_reg[s1_reg.lane] : 8'd0;
    end

    // reconstruction
    always_comb begin
        ab_sum = 9'(a) + 9'(b);
        case (s1_reg.filter)
            FILT_SUB:   pred = a;
            FILT_UP:    pred = b;
            FILT_AVG:   pred = ab_sum[8:1];
            FILT_PAETH: pred = paeth(a, b, c);
            default:    pred = 8'd0;
        endcase
        res = s1_reg.sample + pred;
    end

    // stage and bypass control
    always_comb begin
        s1_next       = s1_reg;
        s1_valid_next = s1_valid_reg;
        fwd_hit_next  = fwd_hit_reg;
        fwd_data_next = fwd_data_reg;
        if (pop) begin
            s1_next       = head_item;
            s1_valid_next = 1'b1;
            fwd_hit_next  = s1_adv && (s1_reg.idx == head_item.idx);
            fwd_data_next = res;
        end else if (s1_adv) begin
            s1_valid_next = 1'b0;
            fwd_hit_next  = 1'b0;
        end
    end

    // output register
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;
        if (s1_adv) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = res;
            m_tlast_next  = s1_reg.last;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            fwd_hit_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            fwd_hit_reg  <= fwd_hit_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        s1_reg       <= s1_next;
        fwd_data_reg <= fwd_data_next;
        m_tdata_reg  <= m_tdata_next;
        m_tlast_reg  <= m_tlast_next;
    end

    // per-lane left and upper-left history
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < 4; k++) begin
                left_reg[k] <= 8'd0;
                ul_reg[k]   <= 8'd0;
            end
        end else if (s1_adv) begin
            left_reg[s1_reg.lane] <= res;
            ul_reg[s1_reg.lane]   <= b;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    `UNF_ASSERT(a_fwd_has_item, !fwd_hit_reg || s1_valid_reg, "bypass flag set with empty stage")
    `UNF_ASSERT_NEXT(a_adv_loads_out, s1_adv, m_tvalid_reg, "advanced sample missing from output")
endmodule

FILE: src/png_scanline_unfilter_core.sv
// PNG scanline filter reconstruction core, top level.
// Depends on png_unf_pkg, png_unf_front, png_unf_fifo, png_unf_back.
//
//  channel | dir | handshake           | payload
//  s_      | in  | s_tvalid/s_tready   | tdata: data_byte; tuser: image_start
//  m_      | out | m_tvalid/m_tready   | tdata: pixel_byte; tlast: row_end
//  cfg_    | in  | cfg_valid/cfg_ready | cfg_index, cfg_wdata
//
// One stream byte per cycle sustained while the output is not stalled; filter bytes are also taken one per cycle.
// A sample passes through the queue, the prior-row read with reconstruction, and the output register.
// The prior-row RAM read is issued when a sample leaves the queue, one per cycle while the back end is not stalled.
// Reset is synchronous on aresetn; the prior-row store needs no clearing pass.
// A stalled output holds the back end; the 4-entry queue absorbs input until it fills.
module png_scanline_unfilter_core
    import png_unf_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [7:0] data_byte
    input  logic [0:0]            s_tuser,   // [0] image_start
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata,   // [7:0] pixel_byte
    output logic                  m_tlast,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);
    logic  push;
    item_t push_item;
    logic  fifo_full;
    logic  pop;
    logic  head_valid;
    item_t head_item;

    png_unf_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .push      (push),
        .push_item (push_item),
        .fifo_full (fifo_full)
    );

    png_unf_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_item  (push_item),
        .full       (fifo_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    png_unf_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_item  (head_item),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );
endmodule
